// ===== hdl/hmtg_pkg.sv =====
package hmtg_pkg;

  // Line store and counter sizing.
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);

  // Field widths.
  localparam int unsigned SizeW   = 11;
  localparam int unsigned RecipW  = 16;
  localparam int unsigned SampleW = 8;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned HeightW = 24;
  localparam int unsigned VtxW    = 23;

  // Vertices per grid cell.
  localparam int unsigned VtxPerCell = 6;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegImageWidth  = 2'd0;
  localparam logic [1:0] RegImageHeight = 2'd1;
  localparam logic [1:0] RegHeightRecip = 2'd2;

  localparam logic [SizeW-1:0]  ResetImageWidth  = 11'd1024;
  localparam logic [SizeW-1:0]  ResetImageHeight = 11'd1024;
  localparam logic [RecipW-1:0] ResetHeightRecip = 16'd13107;

  // Vertex order within a cell.
  typedef enum logic [2:0] {
    VtxTopLeft   = 3'd0,
    VtxTopRight0 = 3'd1,
    VtxBotLeft0  = 3'd2,
    VtxBotLeft1  = 3'd3,
    VtxTopRight1 = 3'd4,
    VtxBotRight  = 3'd5
  } vtx_step_e;

  // One closed grid cell, handed from the line store stage to the emitter.
  typedef struct packed {
    logic [SampleW-1:0]       tl;
    logic [SampleW-1:0]       tr;
    logic [SampleW-1:0]       bl;
    logic [SampleW-1:0]       br;
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] z0;
    logic signed [CoordW-1:0] z1;
    logic [VtxW-1:0]          base;
  } cell_t;

  // Saturate a programmed size to the range 2..maxv.
  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                  input logic [SizeW-1:0] maxv);
    logic [SizeW-1:0] r;
    if (v < SizeW'(2)) begin
      r = SizeW'(2);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hdl/heightmap_triangle_mesh_gen.sv =====
// Channel  | Direction | Handshake                 | Beat contents
// ---------+-----------+---------------------------+----------------------------------------
// in       | input     | in_valid_i / in_ready_o   | height_sample_i
// out      | output    | out_valid_o / out_ready_i | pos_x_twice_o, pos_z_twice_o,
//          |           |                           | height_value_o, vertex_index_o,
//          |           |                           | last_of_cell_o
// cfg      | input     | APB, pready always high   | image_width, image_height, height_recip
//
// A pixel on the first row or column leaves the read stage without emitting a cell. A pixel
// that closes a cell yields six vertex beats, one per vertex, through the single output
// register of the vertex sequencer; the line store read is registered.
// Reset clears counters, left neighbors and handshake state; the line store is not
// cleared and needs no clearing pass. A stalled output holds its beat; the input side
// keeps taking pixels until the read stage and the cell register are both occupied.
module heightmap_triangle_mesh_gen (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [hmtg_pkg::SampleW-1:0]        height_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [hmtg_pkg::CoordW-1:0]  pos_x_twice_o,
  output logic signed [hmtg_pkg::CoordW-1:0]  pos_z_twice_o,
  output logic [hmtg_pkg::HeightW-1:0]        height_value_o,
  output logic [hmtg_pkg::VtxW-1:0]           vertex_index_o,
  output logic                                last_of_cell_o
);

  localparam logic [hmtg_pkg::SizeW-1:0] MaxW = hmtg_pkg::SizeW'(hmtg_pkg::MaxWidth);
  localparam logic [hmtg_pkg::SizeW-1:0] MaxH = hmtg_pkg::SizeW'(hmtg_pkg::MaxHeight);

  logic [hmtg_pkg::SizeW-1:0]   image_width_q;
  logic [hmtg_pkg::SizeW-1:0]   image_height_q;
  logic [hmtg_pkg::RecipW-1:0]  height_recip_q;
  logic [hmtg_pkg::SizeW-1:0]   w_eff;
  logic [hmtg_pkg::SizeW-1:0]   h_eff;
  logic                         cfg_write;
  logic [1:0]                   cfg_index;

  logic [hmtg_pkg::ColW-1:0]    col_q;
  logic [hmtg_pkg::RowW-1:0]    row_q;
  logic                         col_last;
  logic                         row_last;
  logic                         accept;

  logic [hmtg_pkg::SampleW-1:0] row_mem [hmtg_pkg::MaxWidth];
  logic [hmtg_pkg::SampleW-1:0] above_q;

  logic                         s1_valid_q;
  logic [hmtg_pkg::SampleW-1:0] s1_sample_q;
  logic [hmtg_pkg::ColW-1:0]    s1_col_q;
  logic [hmtg_pkg::RowW-1:0]    s1_row_q;
  logic                         s1_emit_q;
  logic                         s1_eof_q;
  logic                         s1_move;

  logic [hmtg_pkg::SampleW-1:0] left_cur_q;
  logic [hmtg_pkg::SampleW-1:0] left_above_q;
  logic [hmtg_pkg::VtxW-1:0]    vcount_q;

  hmtg_pkg::cell_t              cell_data;
  logic                         cell_load;
  logic                         cell_free;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= hmtg_pkg::ResetImageWidth;
      image_height_q <= hmtg_pkg::ResetImageHeight;
      height_recip_q <= hmtg_pkg::ResetHeightRecip;
    end else if (cfg_write) begin
      case (cfg_index)
        hmtg_pkg::RegImageWidth:  image_width_q  <= pwdata[hmtg_pkg::SizeW-1:0];
        hmtg_pkg::RegImageHeight: image_height_q <= pwdata[hmtg_pkg::SizeW-1:0];
        hmtg_pkg::RegHeightRecip: height_recip_q <= pwdata[hmtg_pkg::RecipW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      hmtg_pkg::RegImageWidth:  prdata = 32'(image_width_q);
      hmtg_pkg::RegImageHeight: prdata = 32'(image_height_q);
      hmtg_pkg::RegHeightRecip: prdata = 32'(height_recip_q);
      default:                  prdata = 32'd0;
    endcase
  end

  assign w_eff = hmtg_pkg::clamp_size(image_width_q, MaxW);
  assign h_eff = hmtg_pkg::clamp_size(image_height_q, MaxH);

  // Input handshake: the read stage frees when its pixel moves on.
  assign s1_move    = s1_valid_q && (!s1_emit_q || cell_free);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign accept     = in_valid_i && in_ready_o;

  // Raster position counters; compares are "at or above" so a shrunk size ends at once.
  assign col_last = ((hmtg_pkg::SizeW'(col_q) + hmtg_pkg::SizeW'(1)) >= w_eff);
  assign row_last = ((hmtg_pkg::SizeW'(row_q) + hmtg_pkg::SizeW'(1)) >= h_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_q <= '0;
        if (row_last) begin
          row_q <= '0;
        end else begin
          row_q <= row_q + hmtg_pkg::RowW'(1);
        end
      end else begin
        col_q <= col_q + hmtg_pkg::ColW'(1);
      end
    end
  end

  // Line store: read-first, so the previous row's sample comes out as this one goes in.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      above_q      <= row_mem[col_q];
      row_mem[col_q] <= height_sample_i;
    end
  end

  // Read stage: the pixel waits here for the line store data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= height_sample_i;
      s1_col_q    <= col_q;
      s1_row_q    <= row_q;
      s1_emit_q   <= (col_q != '0) && (row_q != '0);
      s1_eof_q    <= col_last && row_last;
    end
  end

  // Left neighbors and the frame's vertex counter advance in pixel order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cur_q   <= '0;
      left_above_q <= '0;
      vcount_q     <= '0;
    end else if (s1_move) begin
      left_cur_q   <= s1_sample_q;
      left_above_q <= above_q;
      if (s1_eof_q) begin
        vcount_q <= '0;
      end else if (s1_emit_q) begin
        vcount_q <= vcount_q + hmtg_pkg::VtxW'(hmtg_pkg::VtxPerCell);
      end
    end
  end

  // Cell corners and doubled, centered coordinates.
  always_comb begin
    cell_data.tl   = left_above_q;
    cell_data.tr   = above_q;
    cell_data.bl   = left_cur_q;
    cell_data.br   = s1_sample_q;
    cell_data.x1   = hmtg_pkg::CoordW'({s1_col_q, 1'b0}) - hmtg_pkg::CoordW'(w_eff);
    cell_data.x0   = cell_data.x1 - hmtg_pkg::CoordW'(2);
    cell_data.z1   = hmtg_pkg::CoordW'({s1_row_q, 1'b0}) - hmtg_pkg::CoordW'(h_eff);
    cell_data.z0   = cell_data.z1 - hmtg_pkg::CoordW'(2);
    cell_data.base = vcount_q;
  end

  assign cell_load = s1_move && s1_emit_q;

  hmtg_vertex_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cell_load_i    (cell_load),
    .cell_i         (cell_data),
    .recip_i        (height_recip_q),
    .cell_free_o    (cell_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pos_x_twice_o  (pos_x_twice_o),
    .pos_z_twice_o  (pos_z_twice_o),
    .height_value_o (height_value_o),
    .vertex_index_o (vertex_index_o),
    .last_of_cell_o (last_of_cell_o)
  );

endmodule

// ===== hdl/hmtg_vertex_emit.sv =====
module hmtg_vertex_emit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cell_load_i,
  input  hmtg_pkg::cell_t                     cell_i,
  input  logic [hmtg_pkg::RecipW-1:0]         recip_i,
  output logic                                cell_free_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [hmtg_pkg::CoordW-1:0]  pos_x_twice_o,
  output logic signed [hmtg_pkg::CoordW-1:0]  pos_z_twice_o,
  output logic [hmtg_pkg::HeightW-1:0]        height_value_o,
  output logic [hmtg_pkg::VtxW-1:0]           vertex_index_o,
  output logic                                last_of_cell_o
);

  logic                               cell_valid_q;
  hmtg_pkg::cell_t                    cell_q;
  hmtg_pkg::vtx_step_e                step_q;
  hmtg_pkg::vtx_step_e                step_next;
  logic                               emit_go;
  logic                               last_step;
  logic [hmtg_pkg::SampleW-1:0]       sel_sample;
  logic signed [hmtg_pkg::CoordW-1:0] sel_x;
  logic signed [hmtg_pkg::CoordW-1:0] sel_z;
  logic                               out_valid_q;

  // Corner selection for the vertex at hand.
  always_comb begin
    sel_sample = cell_q.tl;
    sel_x      = cell_q.x0;
    sel_z      = cell_q.z0;
    step_next  = hmtg_pkg::VtxTopLeft;
    case (step_q)
      hmtg_pkg::VtxTopLeft: begin
        sel_sample = cell_q.tl;
        sel_x      = cell_q.x0;
        sel_z      = cell_q.z0;
        step_next  = hmtg_pkg::VtxTopRight0;
      end
      hmtg_pkg::VtxTopRight0: begin
        sel_sample = cell_q.tr;
        sel_x      = cell_q.x1;
        sel_z      = cell_q.z0;
        step_next  = hmtg_pkg::VtxBotLeft0;
      end
      hmtg_pkg::VtxBotLeft0: begin
        sel_sample = cell_q.bl;
        sel_x      = cell_q.x0;
        sel_z      = cell_q.z1;
        step_next  = hmtg_pkg::VtxBotLeft1;
      end
      hmtg_pkg::VtxBotLeft1: begin
        sel_sample = cell_q.bl;
        sel_x      = cell_q.x0;
        sel_z      = cell_q.z1;
        step_next  = hmtg_pkg::VtxTopRight1;
      end
      hmtg_pkg::VtxTopRight1: begin
        sel_sample = cell_q.tr;
        sel_x      = cell_q.x1;
        sel_z      = cell_q.z0;
        step_next  = hmtg_pkg::VtxBotRight;
      end
      hmtg_pkg::VtxBotRight: begin
        sel_sample = cell_q.br;
        sel_x      = cell_q.x1;
        sel_z      = cell_q.z1;
        step_next  = hmtg_pkg::VtxTopLeft;
      end
      default: begin
        sel_sample = cell_q.tl;
        sel_x      = cell_q.x0;
        sel_z      = cell_q.z0;
        step_next  = hmtg_pkg::VtxTopLeft;
      end
    endcase
  end

  // A vertex moves into the output register whenever that register frees up.
  assign emit_go     = cell_valid_q && (!out_valid_q || out_ready_i);
  assign last_step   = (step_q == hmtg_pkg::VtxBotRight);
  assign cell_free_o = !cell_valid_q || (emit_go && last_step);

  // Cell holding register and vertex sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_valid_q <= 1'b0;
      step_q       <= hmtg_pkg::VtxTopLeft;
    end else if (cell_load_i) begin
      cell_valid_q <= 1'b1;
      step_q       <= hmtg_pkg::VtxTopLeft;
    end else if (emit_go) begin
      if (last_step) begin
        cell_valid_q <= 1'b0;
      end
      step_q <= step_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_load_i) begin
      cell_q <= cell_i;
    end
  end

  // Output register: one vertex beat at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      pos_x_twice_o  <= sel_x;
      pos_z_twice_o  <= sel_z;
      height_value_o <= hmtg_pkg::HeightW'(sel_sample) * hmtg_pkg::HeightW'(recip_i);
      vertex_index_o <= cell_q.base + hmtg_pkg::VtxW'(step_q);
      last_of_cell_o <= last_step;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
